FILE: src/ssi_pkg.sv
// Shared widths, status codes and register map for the segment intersection block.
// No dependencies.
`default_nettype none
package ssi_pkg;
	localparam int COORD_W   = 16;
	localparam int DIFF_W    = COORD_W + 1;
	localparam int PROD_W    = 2 * DIFF_W;
	localparam int DET_W     = PROD_W + 1;
	localparam int MAG_W     = DET_W - 1;
	localparam int TOL_W     = 16;
	localparam int WIDE_W    = 52;
	localparam int SUM_W     = WIDE_W + 1;
	localparam int FRAC_W    = 8;
	localparam int NUM_W     = SUM_W - 1 + FRAC_W;
	localparam int OUT_W     = 25;
	localparam int DIV_STEPS = OUT_W - 1;
	localparam int DIV_LAT   = DIV_STEPS + 1;
	localparam int PIPE_LAT  = 7 + DIV_LAT + 1;
	localparam int DATA_W    = 64;
	localparam int ADDR_W    = 4;

	localparam logic signed [OUT_W-1:0] Q_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] Q_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	localparam logic REG_DET = 1'b0;
	localparam logic REG_TOL = 1'b1;

	typedef enum logic [1:0] {
		ST_HIT      = 2'd0,
		ST_MISS     = 2'd1,
		ST_PARALLEL = 2'd2
	} status_t;
endpackage
`default_nettype wire

FILE: src/segment_segment_intersection_top.sv
// Top level of the 2D segment intersection block: APB register file and arithmetic pipeline.
// Depends on ssi_pkg and ssi_div.
//
// Usage: drive the eight 16-bit signed segment coordinates and pulse start; a word is
// taken at every edge where start is high and busy is low. busy is always low, so a
// new segment pair may enter in every cycle and the block runs at one pair per clock.
// Each accepted word yields exactly one result word (status, cross_x, cross_y) that
// sits on the result ports for one cycle, flagged by done. Each word passes through
// 33 register stages: seven arithmetic stages (differences, products, determinant,
// sign fold, scaling products, sums and range test, magnitude), the divider's entry
// stage, its 24 quotient steps, and the output register.
// The receiver cannot stall: results are strobed out and must be captured.
// Config: det_threshold at byte address 0, param_tolerance at 8, 64-bit data bus.
// Write registers only while no pair is in flight.
// Reset (arst_n low) empties the pipeline and restores det_threshold = 1, tolerance 0.
`default_nettype none
module segment_segment_intersection_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic signed [15:0]              a_start_x,
	input  wire logic signed [15:0]              a_start_y,
	input  wire logic signed [15:0]              a_end_x,
	input  wire logic signed [15:0]              a_end_y,
	input  wire logic signed [15:0]              b_start_x,
	input  wire logic signed [15:0]              b_start_y,
	input  wire logic signed [15:0]              b_end_x,
	input  wire logic signed [15:0]              b_end_y,
	output logic                                 done,
	output logic [1:0]                           status,
	output logic signed [24:0]                   cross_x,
	output logic signed [24:0]                   cross_y,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [ssi_pkg::ADDR_W-1:0]      paddr,
	input  wire logic [ssi_pkg::DATA_W-1:0]      pwdata,
	output logic [ssi_pkg::DATA_W-1:0]           prdata,
	output logic                                 pready
);
	import ssi_pkg::*;

	// ---------------- register file ----------------
	logic [DET_W-1:0] det_threshold_q;
	logic [TOL_W-1:0] param_tolerance_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_threshold_q   <= DET_W'(1);
			param_tolerance_q <= '0;
		end else if (wr_en) begin
			unique case (paddr[3])
				REG_DET: det_threshold_q   <= pwdata[DET_W-1:0];
				REG_TOL: param_tolerance_q <= pwdata[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3])
			REG_DET: prdata = DATA_W'(det_threshold_q);
			REG_TOL: prdata = DATA_W'(param_tolerance_q);
			default: prdata = '0;
		endcase
	end

	// ---------------- valid line ----------------
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// s1: direction vectors and start offset
	logic signed [DIFF_W-1:0]  wx_s1, wy_s1, vx_s1, vy_s1, dx_s1, dy_s1;
	logic signed [COORD_W-1:0] ax_s1, ay_s1;

	always_ff @(posedge clk) begin
		wx_s1 <= DIFF_W'(a_end_x) - DIFF_W'(a_start_x);
		wy_s1 <= DIFF_W'(a_end_y) - DIFF_W'(a_start_y);
		vx_s1 <= DIFF_W'(b_end_x) - DIFF_W'(b_start_x);
		vy_s1 <= DIFF_W'(b_end_y) - DIFF_W'(b_start_y);
		dx_s1 <= DIFF_W'(b_start_x) - DIFF_W'(a_start_x);
		dy_s1 <= DIFF_W'(b_start_y) - DIFF_W'(a_start_y);
		ax_s1 <= a_start_x;
		ay_s1 <= a_start_y;
	end

	// s2: the six cross products
	logic signed [PROD_W-1:0]  p_wv_s2, p_vw_s2, p_vd_s2, p_vdy_s2, p_wd_s2, p_wdy_s2;
	logic signed [DIFF_W-1:0]  wx_s2, wy_s2;
	logic signed [COORD_W-1:0] ax_s2, ay_s2;

	always_ff @(posedge clk) begin
		p_wv_s2  <= wx_s1 * vy_s1;
		p_vw_s2  <= vx_s1 * wy_s1;
		p_vd_s2  <= vy_s1 * dx_s1;
		p_vdy_s2 <= vx_s1 * dy_s1;
		p_wd_s2  <= wy_s1 * dx_s1;
		p_wdy_s2 <= wx_s1 * dy_s1;
		wx_s2    <= wx_s1;
		wy_s2    <= wy_s1;
		ax_s2    <= ax_s1;
		ay_s2    <= ay_s1;
	end

	// s3: determinant and the two Cramer numerators
	logic signed [DET_W-1:0]   det_s3, sn_s3, tn_s3;
	logic signed [DIFF_W-1:0]  wx_s3, wy_s3;
	logic signed [COORD_W-1:0] ax_s3, ay_s3;

	always_ff @(posedge clk) begin
		det_s3 <= DET_W'(p_wv_s2) - DET_W'(p_vw_s2);
		sn_s3  <= DET_W'(p_vd_s2) - DET_W'(p_vdy_s2);
		tn_s3  <= DET_W'(p_wd_s2) - DET_W'(p_wdy_s2);
		wx_s3  <= wx_s2;
		wy_s3  <= wy_s2;
		ax_s3  <= ax_s2;
		ay_s3  <= ay_s2;
	end

	// s4: fold the sign of det into the numerators, test for parallel lines
	logic signed [DET_W-1:0]   det_abs;
	logic [MAG_W-1:0]          detm_s4;
	logic signed [DET_W-1:0]   sn_s4, tn_s4;
	logic                      par_s4;
	logic signed [DIFF_W-1:0]  wx_s4, wy_s4;
	logic signed [COORD_W-1:0] ax_s4, ay_s4;

	assign det_abs = det_s3[DET_W-1] ? -det_s3 : det_s3;

	always_ff @(posedge clk) begin
		detm_s4 <= det_abs[MAG_W-1:0];
		sn_s4   <= det_s3[DET_W-1] ? -sn_s3 : sn_s3;
		tn_s4   <= det_s3[DET_W-1] ? -tn_s3 : tn_s3;
		par_s4  <= (det_s3 == '0) || ($unsigned(det_abs) < det_threshold_q);
		wx_s4   <= wx_s3;
		wy_s4   <= wy_s3;
		ax_s4   <= ax_s3;
		ay_s4   <= ay_s3;
	end

	// s5: scale by det for the point, tolerance times det for the range test
	logic signed [WIDE_W-1:0]  bdx_s5, bdy_s5, wsx_s5, wsy_s5;
	logic [WIDE_W-3:0]         tdet_s5;
	logic [MAG_W-1:0]          detm_s5;
	logic signed [DET_W-1:0]   sn_s5, tn_s5;
	logic                      par_s5;

	always_ff @(posedge clk) begin
		bdx_s5  <= ax_s4 * $signed({1'b0, detm_s4});
		bdy_s5  <= ay_s4 * $signed({1'b0, detm_s4});
		wsx_s5  <= wx_s4 * sn_s4;
		wsy_s5  <= wy_s4 * sn_s4;
		tdet_s5 <= param_tolerance_q * detm_s4;
		detm_s5 <= detm_s4;
		sn_s5   <= sn_s4;
		tn_s5   <= tn_s4;
		par_s5  <= par_s4;
	end

	// s6: numerators of the point and the exact range test on s and t
	logic signed [SUM_W-1:0] lo_b, hi_b, sl, tl;
	logic signed [SUM_W-1:0] numx_s6, numy_s6;
	logic [MAG_W-1:0]        detm_s6;
	logic [1:0]              st_s6;

	assign lo_b = -$signed(SUM_W'(tdet_s5));
	assign hi_b = $signed(SUM_W'({detm_s5, 16'b0}) + SUM_W'(tdet_s5));
	assign sl   = SUM_W'(sn_s5) <<< 16;
	assign tl   = SUM_W'(tn_s5) <<< 16;

	always_ff @(posedge clk) begin
		numx_s6 <= SUM_W'(bdx_s5) + SUM_W'(wsx_s5);
		numy_s6 <= SUM_W'(bdy_s5) + SUM_W'(wsy_s5);
		detm_s6 <= detm_s5;
		if (par_s5) begin
			st_s6 <= ST_PARALLEL;
		end else if (sl >= lo_b && sl <= hi_b && tl >= lo_b && tl <= hi_b) begin
			st_s6 <= ST_HIT;
		end else begin
			st_s6 <= ST_MISS;
		end
	end

	// s7: sign and magnitude of the Q.8 numerators for the divider
	logic signed [SUM_W-1:0] absx, absy;
	logic [NUM_W-1:0]        magx_s7, magy_s7;
	logic                    negx_s7, negy_s7;
	logic [MAG_W-1:0]        detm_s7;
	logic [1:0]              st_s7;

	assign absx = numx_s6[SUM_W-1] ? -numx_s6 : numx_s6;
	assign absy = numy_s6[SUM_W-1] ? -numy_s6 : numy_s6;

	always_ff @(posedge clk) begin
		magx_s7 <= {absx[SUM_W-2:0], FRAC_W'(0)};
		magy_s7 <= {absy[SUM_W-2:0], FRAC_W'(0)};
		negx_s7 <= numx_s6[SUM_W-1];
		negy_s7 <= numy_s6[SUM_W-1];
		detm_s7 <= detm_s6;
		st_s7   <= st_s6;
	end

	// divide both coordinates by |det|
	logic                    dvx_valid, dvy_valid;
	logic signed [OUT_W-1:0] qx, qy;

	ssi_div u_div_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s7),
		.in_mag    (magx_s7),
		.in_neg    (negx_s7),
		.in_det    (detm_s7),
		.out_valid (dvx_valid),
		.out_q     (qx)
	);

	ssi_div u_div_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s7),
		.in_mag    (magy_s7),
		.in_neg    (negy_s7),
		.in_det    (detm_s7),
		.out_valid (dvy_valid),
		.out_q     (qy)
	);

	// status rides alongside the divider
	logic [1:0] st_d [0:DIV_LAT-1];

	always_ff @(posedge clk) begin
		st_d[0] <= st_s7;
		for (int i = 1; i < DIV_LAT; i++) begin
			st_d[i] <= st_d[i-1];
		end
	end

	// output register: one-cycle strobe, zero point when parallel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dvx_valid && dvy_valid;
		end
	end

	always_ff @(posedge clk) begin
		status  <= st_d[DIV_LAT-1];
		cross_x <= (st_d[DIV_LAT-1] == ST_PARALLEL) ? '0 : qx;
		cross_y <= (st_d[DIV_LAT-1] == ST_PARALLEL) ? '0 : qy;
	end

	// ---------------- assertions ----------------
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		dvx_valid == dvy_valid)
		else $error("coordinate dividers out of step");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_LAT))
		else $error("result without matching accepted word");

	a_parallel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_PARALLEL) |-> (cross_x == '0 && cross_y == '0))
		else $error("parallel result carries a point");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_HIT || status == ST_MISS || status == ST_PARALLEL))
		else $error("bad status code");
endmodule
`default_nettype wire

FILE: src/ssi_div.sv
// Pipelined restoring divider: one quotient bit per stage, saturating signed result.
// Depends on ssi_pkg.
`default_nettype none
module ssi_div (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	input  wire logic [ssi_pkg::NUM_W-1:0]         in_mag,
	input  wire logic                              in_neg,
	input  wire logic [ssi_pkg::MAG_W-1:0]         in_det,
	output logic                                   out_valid,
	output logic signed [ssi_pkg::OUT_W-1:0]       out_q
);
	import ssi_pkg::*;

	logic                 vld_s [0:DIV_STEPS];
	logic [NUM_W-1:0]     rem_s [0:DIV_STEPS];
	logic [DIV_STEPS-1:0] q_s   [0:DIV_STEPS];
	logic [MAG_W-1:0]     det_s [0:DIV_STEPS];
	logic                 neg_s [0:DIV_STEPS];
	logic                 ovf_s [0:DIV_STEPS];

	// entry stage: flag quotients that exceed the saturation limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= in_mag;
		q_s[0]   <= '0;
		det_s[0] <= in_det;
		neg_s[0] <= in_neg;
		ovf_s[0] <= in_mag >= (NUM_W'(in_det) << DIV_STEPS);
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic [NUM_W-1:0] trial;
		logic             ge;
		assign trial = NUM_W'(det_s[k]) << (DIV_STEPS - 1 - k);
		assign ge    = rem_s[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? rem_s[k] - trial : rem_s[k];
			q_s[k+1]   <= q_s[k] | (DIV_STEPS'(ge) << (DIV_STEPS - 1 - k));
			det_s[k+1] <= det_s[k];
			neg_s[k+1] <= neg_s[k];
			ovf_s[k+1] <= ovf_s[k];
		end
	end

	logic signed [OUT_W-1:0] qpos;
	assign qpos = $signed({1'b0, q_s[DIV_STEPS]});

	always_comb begin
		if (ovf_s[DIV_STEPS]) begin
			out_q = neg_s[DIV_STEPS] ? Q_MIN : Q_MAX;
		end else begin
			out_q = neg_s[DIV_STEPS] ? -qpos : qpos;
		end
	end

	assign out_valid = vld_s[DIV_STEPS];
endmodule
`default_nettype wire
